FILE: rtl/core/radar_measurement_jacobian_defines.svh
// ----------------------------------------------------------------------------
// radar measurement jacobian assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH

// same-cycle implication
`define RMJ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// widths, sideband types and the output clipping function of the jacobian
// ----------------------------------------------------------------------------
package rmj_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int R2_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int C4_W    = 65;
  localparam int QUO_W   = 33;
  localparam int NUM_MAX = 113;
  localparam int DEN_MAX = 96;
  localparam int LANES   = 6;
  localparam int THR_W   = 16;

  // sideband carried along the square root cells
  typedef struct packed {
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] q;
    logic [3:0]        sg;
    logic              sc4;
    logic [C4_W-1:0]   c4;
    logic [R2_W-1:0]   r2;
    logic              near;
  } sq_side_t;

  // sideband carried along the divider cells
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             near;
  } dv_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              sat;
  } emit_t;

  function automatic emit_t rmj_emit(input logic [QUO_W-1:0] quo, input logic neg);
    logic [QUO_W-1:0]  lim;
    logic [QUO_W-1:0]  mag;
    emit_t             res;
    lim      = neg ? (QUO_W'(1) << (DATA_W - 1)) : ((QUO_W'(1) << (DATA_W - 1)) - QUO_W'(1));
    res.sat  = quo > lim;
    mag      = res.sat ? lim : quo;
    res.data = neg ? (DATA_W'(0) - mag[DATA_W-1:0]) : mag[DATA_W-1:0];
    return res;
  endfunction

endpackage

FILE: rtl/core/rmj_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmj_sqrt_cell
// one bit of the digit-by-digit integer square root of range squared
// ----------------------------------------------------------------------------
module rmj_sqrt_cell
  import rmj_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic              clk_i,
  input  logic              ce_i,
  input  logic [R2_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [R2_W-1:0]   rem_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int TW = R2_W + 2;

  logic [TW-1:0]     trial;
  logic              take;
  logic [R2_W-1:0]   rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;

  // (2*root + 2^bit) * 2^bit
  always_comb begin
    trial  = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    take   = TW'(rem_i) >= trial;
    rem_d  = take ? R2_W'(TW'(rem_i) - trial) : rem_i;
    root_d = take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/rmj_div_cell.sv
// ----------------------------------------------------------------------------
// rmj_div_cell
// one quotient bit of a restoring divider lane
// ----------------------------------------------------------------------------
module rmj_div_cell
  import rmj_pkg::*;
#(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int SHIFT = 0
) (
  input  logic             clk_i,
  input  logic             ce_i,
  input  logic [NUM_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [QUO_W-1:0] quo_i,
  output logic [NUM_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CW = ((NUM_W > DEN_W + SHIFT) ? NUM_W : DEN_W + SHIFT) + 1;

  logic [CW-1:0]    trial;
  logic             take;
  logic [NUM_W-1:0] rem_d, rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] quo_d, quo_q;

  always_comb begin
    trial = CW'(den_i) << SHIFT;
    take  = CW'(rem_i) >= trial;
    rem_d = take ? NUM_W'(CW'(rem_i) - trial) : rem_i;
    quo_d = quo_i | (QUO_W'(take) << SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

FILE: rtl/core/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// radar range / bearing / range-rate jacobian of a 2d constant velocity state
// ----------------------------------------------------------------------------
// usage:
//   input beats on s_axis carry pos_x, pos_y, vel_x, vel_y in signed q16.16
//   result beats on m_axis carry the six distinct jacobian entries plus the
//   near zero and saturation flags in tuser
//   cfg_data_i writes the range squared threshold; cfg_ready_o is always high
// throughput and structure:
//   one beat per cycle unless a result waits on m_axis; the pipeline is
//   made of the 32 square root cells and the 33 divider cells
//   plus five arithmetic stages and the output register
// reset:
//   rst_ni clears the pipeline valids and loads the threshold with 7
// stall:
//   while a result waits on m_axis the whole pipeline holds and s_axis_tready
//   drops; it rises again in the cycle the waiting beat is taken
// ----------------------------------------------------------------------------
`include "radar_measurement_jacobian_defines.svh"

module radar_measurement_jacobian
  import rmj_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,    // min_range_squared
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy, drate_dpx, drate_dpy
  output logic [191:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // near_zero_error, saturated
);

  localparam int SQ_N  = ROOT_W;
  localparam int DV_N  = QUO_W;
  localparam int VLD_N = 3 + SQ_N + 2 + DV_N;

  // global advance: the pipeline moves whenever the output register is free or its beat is taken
  logic ce;
  logic [VLD_N-1:0] vld_q;
  logic             m_valid_q;
  logic [THR_W-1:0] thr_q;

  assign ce            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = ce;
  assign cfg_ready_o   = 1'b1;

  // ---------------- stage 1: sign / magnitude ----------------
  logic [DATA_W-1:0] in_v   [4];
  logic [DATA_W-1:0] in_mag [4];
  logic [3:0]        in_sg;
  logic [DATA_W-1:0] s1_mag_q [4];
  logic [3:0]        s1_sg_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_v[i]   = s_axis_tdata[i*DATA_W +: DATA_W];
      in_sg[i]  = in_v[i][DATA_W-1];
      in_mag[i] = in_sg[i] ? (DATA_W'(0) - in_v[i]) : in_v[i];
    end
  end

  // ---------------- stage 2: squares and cross products ----------------
  logic [R2_W-1:0]   s2_pp_q, s2_qq_q, s2_vxq_q, s2_vyp_q;
  logic [DATA_W-1:0] s2_p_q, s2_q_q;
  logic [3:0]        s2_sg_q;

  // ---------------- stage 3: range squared, cross term, threshold ----------------
  logic [R2_W-1:0]   r2_sum;
  logic [C4_W:0]     c4_t1, c4_t2, c4_sum;
  logic              c4_sa, c4_sb;
  logic [R2_W-1:0]   thr_full;
  sq_side_t          sq3_d;

  always_comb begin
    r2_sum   = s2_pp_q + s2_qq_q;
    c4_sa    = s2_sg_q[2] ^ s2_sg_q[1];
    c4_sb    = !(s2_sg_q[3] ^ s2_sg_q[0]);
    c4_t1    = c4_sa ? ((C4_W+1)'(0) - (C4_W+1)'(s2_vxq_q)) : (C4_W+1)'(s2_vxq_q);
    c4_t2    = c4_sb ? ((C4_W+1)'(0) - (C4_W+1)'(s2_vyp_q)) : (C4_W+1)'(s2_vyp_q);
    c4_sum   = c4_t1 + c4_t2;
    thr_full = R2_W'(thr_q) << FRAC_W;
    sq3_d.p    = s2_p_q;
    sq3_d.q    = s2_q_q;
    sq3_d.sg   = s2_sg_q;
    sq3_d.sc4  = c4_sum[C4_W];
    sq3_d.c4   = c4_sum[C4_W] ? C4_W'((C4_W+1)'(0) - c4_sum) : c4_sum[C4_W-1:0];
    sq3_d.r2   = r2_sum;
    sq3_d.near = (r2_sum == '0) || (r2_sum < thr_full);
  end

  // ---------------- square root cells ----------------
  sq_side_t          sq_q   [SQ_N+1];
  logic [R2_W-1:0]   sq_rem [SQ_N+1];
  logic [ROOT_W-1:0] sq_root[SQ_N+1];

  assign sq_rem[0]  = sq_q[0].r2;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    rmj_sqrt_cell #(
      .BIT(SQ_N - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .ce_i   (ce),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // ---------------- stage 4: partial products of the wide terms ----------------
  sq_side_t          s4_side_q;
  logic [ROOT_W-1:0] s4_s_q;
  logic [R2_W-1:0]   s4_r2lo_q, s4_r2hi_q, s4_qlo_q, s4_qhi_q, s4_plo_q, s4_phi_q;

  // ---------------- stage 5: divider operands ----------------
  logic [NUM_MAX-1:0] s5_num_q [LANES];
  logic [DEN_MAX-1:0] s5_den_q [LANES];
  logic [NUM_MAX-1:0] num_d [LANES];
  logic [DEN_MAX-1:0] den_d [LANES];
  logic [C4_W+DATA_W-1:0] qc4, pc4;
  dv_side_t           dv5_d;

  always_comb begin
    qc4 = (C4_W+DATA_W)'(s4_qlo_q) + ((C4_W+DATA_W)'(s4_qhi_q) << 32)
        + (s4_side_q.c4[C4_W-1] ? ((C4_W+DATA_W)'(s4_side_q.q) << 64) : '0);
    pc4 = (C4_W+DATA_W)'(s4_plo_q) + ((C4_W+DATA_W)'(s4_phi_q) << 32)
        + (s4_side_q.c4[C4_W-1] ? ((C4_W+DATA_W)'(s4_side_q.p) << 64) : '0);
    num_d[0] = NUM_MAX'(s4_side_q.p) << FRAC_W;
    num_d[1] = NUM_MAX'(s4_side_q.q) << FRAC_W;
    num_d[2] = NUM_MAX'(s4_side_q.q) << (2 * FRAC_W);
    num_d[3] = NUM_MAX'(s4_side_q.p) << (2 * FRAC_W);
    num_d[4] = NUM_MAX'(qc4) << FRAC_W;
    num_d[5] = NUM_MAX'(pc4) << FRAC_W;
    den_d[0] = DEN_MAX'(s4_s_q);
    den_d[1] = DEN_MAX'(s4_s_q);
    den_d[2] = DEN_MAX'(s4_side_q.r2);
    den_d[3] = DEN_MAX'(s4_side_q.r2);
    den_d[4] = DEN_MAX'(s4_r2lo_q) + (DEN_MAX'(s4_r2hi_q) << 32);
    den_d[5] = den_d[4];
    // lane signs: range row, bearing row, range-rate row
    dv5_d.neg[0] = s4_side_q.sg[0];
    dv5_d.neg[1] = s4_side_q.sg[1];
    dv5_d.neg[2] = !s4_side_q.sg[1];
    dv5_d.neg[3] = s4_side_q.sg[0];
    dv5_d.neg[4] = s4_side_q.sg[1] ^ s4_side_q.sc4;
    dv5_d.neg[5] = !(s4_side_q.sg[0] ^ s4_side_q.sc4);
    dv5_d.near   = s4_side_q.near;
  end

  // ---------------- divider cells, six lanes ----------------
  dv_side_t         dv_q [DV_N+1];
  logic [QUO_W-1:0] lane_quo [LANES];

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    localparam int NW = (j < 2) ? 48 : (j < 4) ? 64 : NUM_MAX;
    localparam int DW = (j < 2) ? ROOT_W : (j < 4) ? R2_W : DEN_MAX;

    logic [NW-1:0]    rem_w [DV_N+1];
    logic [DW-1:0]    den_w [DV_N+1];
    logic [QUO_W-1:0] quo_w [DV_N+1];

    assign rem_w[0] = s5_num_q[j][NW-1:0];
    assign den_w[0] = s5_den_q[j][DW-1:0];
    assign quo_w[0] = '0;

    for (genvar k = 0; k < DV_N; k++) begin : g_cell
      rmj_div_cell #(
        .NUM_W (NW),
        .DEN_W (DW),
        .SHIFT (DV_N - 1 - k)
      ) u_cell (
        .clk_i (clk_i),
        .ce_i  (ce),
        .rem_i (rem_w[k]),
        .den_i (den_w[k]),
        .quo_i (quo_w[k]),
        .rem_o (rem_w[k+1]),
        .den_o (den_w[k+1]),
        .quo_o (quo_w[k+1])
      );
    end

    assign lane_quo[j] = quo_w[DV_N];
  end

  // ---------------- output: clip, flags ----------------
  emit_t          lane_res [LANES];
  logic [191:0]   out_data_d;
  logic [1:0]     out_user_d;
  logic           any_sat;
  logic [191:0]   m_data_q;
  logic [1:0]     m_user_q;

  always_comb begin
    any_sat = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      lane_res[j] = rmj_emit(lane_quo[j], dv_q[DV_N].neg[j]);
      any_sat     = any_sat | lane_res[j].sat;
      out_data_d[j*DATA_W +: DATA_W] = dv_q[DV_N].near ? '0 : lane_res[j].data;
    end
    out_user_d[0] = dv_q[DV_N].near;
    out_user_d[1] = !dv_q[DV_N].near && any_sat;
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        s1_mag_q[i] <= in_mag[i];
      end
      s1_sg_q  <= in_sg;

      s2_pp_q  <= R2_W'(s1_mag_q[0] * s1_mag_q[0]);
      s2_qq_q  <= R2_W'(s1_mag_q[1] * s1_mag_q[1]);
      s2_vxq_q <= R2_W'(s1_mag_q[2] * s1_mag_q[1]);
      s2_vyp_q <= R2_W'(s1_mag_q[3] * s1_mag_q[0]);
      s2_p_q   <= s1_mag_q[0];
      s2_q_q   <= s1_mag_q[1];
      s2_sg_q  <= s1_sg_q;

      sq_q[0] <= sq3_d;
      for (int k = 0; k < SQ_N; k++) begin
        sq_q[k+1] <= sq_q[k];
      end

      s4_side_q <= sq_q[SQ_N];
      s4_s_q    <= sq_root[SQ_N];
      s4_r2lo_q <= R2_W'(sq_q[SQ_N].r2[31:0] * sq_root[SQ_N]);
      s4_r2hi_q <= R2_W'(sq_q[SQ_N].r2[63:32] * sq_root[SQ_N]);
      s4_qlo_q  <= R2_W'(sq_q[SQ_N].c4[31:0] * sq_q[SQ_N].q);
      s4_qhi_q  <= R2_W'(sq_q[SQ_N].c4[63:32] * sq_q[SQ_N].q);
      s4_plo_q  <= R2_W'(sq_q[SQ_N].c4[31:0] * sq_q[SQ_N].p);
      s4_phi_q  <= R2_W'(sq_q[SQ_N].c4[63:32] * sq_q[SQ_N].p);

      for (int j = 0; j < LANES; j++) begin
        s5_num_q[j] <= num_d[j];
        s5_den_q[j] <= den_d[j];
      end
      dv_q[0] <= dv5_d;
      for (int k = 0; k < DV_N; k++) begin
        dv_q[k+1] <= dv_q[k];
      end

      m_data_q <= out_data_d;
      m_user_q <= out_user_d;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
      thr_q     <= THR_W'(7);
    end else begin
      if (ce) begin
        vld_q     <= {vld_q[VLD_N-2:0], s_axis_tvalid};
        m_valid_q <= vld_q[VLD_N-1];
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------- assertions ----------------
  `RMJ_ASSERT_SAME(a_near_zero_clean, m_axis_tvalid && m_axis_tuser[0],
                   (m_axis_tdata == '0) && !m_axis_tuser[1], "near zero beat not cleared")
  `RMJ_ASSERT_NEXT(a_hold_on_stall, !ce, $stable(vld_q), "pipeline moved during stall")
  `RMJ_ASSERT_NEXT(a_tail_reaches_out, ce && vld_q[VLD_N-1], m_axis_tvalid,
                   "result lost at output register")

endmodule

FILE: test/radar_measurement_jacobian_tb.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_tb
// self-checking bench for the radar jacobian: state vectors go in on s_axis,
// each result beat on m_axis is checked against an in-bench fixed-point
// predictor over several threshold settings, with random gaps and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radar_measurement_jacobian_tb;
  import rmj_pkg::*;

  localparam int NFIELD    = 6;
  localparam int HOLD_LEN  = 300;  // long receiver hold-off, beyond pipeline depth
  localparam int DRAIN_CYC = 90;   // drain wait, longer than the pipeline depth

  typedef logic signed [255:0] wide_t;

  // one predicted result beat
  typedef struct packed {
    logic [NFIELD*DATA_W-1:0] d;
    logic                     sat;
    logic                     near;
  } jac_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // pos_x, pos_y, vel_x, vel_y
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;        // six jacobian entries, drange_dpx lowest
  logic [1:0]   m_axis_tuser;        // near_zero_error, saturated

  radar_measurement_jacobian uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [127:0] state_q[$];     // state vectors waiting to be sent
  jac_t         jac_q[$];       // predicted result beats, oldest first
  logic [15:0]  min_r2 = 16'd7; // mirror of the threshold register
  bit           calm = 1'b0;    // no random gaps or stalls on either side while set
  int           n_err = 0;
  int           n_sent = 0;
  int           n_got = 0;
  int           n_near = 0;
  int           n_sat = 0;

  // quotient truncated toward zero, clipped to data width; bit 32 flags a clip
  function automatic logic [32:0] clip_div(wide_t num, wide_t den);
    wide_t quo;
    quo = num / den;
    if (quo > wide_t'(32'sh7fff_ffff)) return {1'b1, 32'h7fff_ffff};
    if (quo < -(wide_t'(1) <<< 31)) return {1'b1, 32'h8000_0000};
    return {1'b0, quo[31:0]};
  endfunction

  // range / bearing / range-rate partials of one state vector
  function automatic jac_t jacobian_of(logic [127:0] st, logic [15:0] thr);
    wide_t px, py, vx, vy, r2, rt, cand, c4, den3, lim;
    wide_t num[NFIELD];
    logic [32:0] e;
    jac_t r;
    px = $signed(st[31:0]);
    py = $signed(st[63:32]);
    vx = $signed(st[95:64]);
    vy = $signed(st[127:96]);
    r = '0;
    lim = thr;
    lim = lim <<< FRAC_W;
    r2 = px * px + py * py;
    if (r2 == 0 || r2 < lim) begin
      r.near = 1'b1;
      return r;
    end
    rt = 0;
    for (int i = 33; i >= 0; i--) begin
      cand = rt + (wide_t'(1) <<< i);
      if (cand * cand <= r2) rt = cand;
    end
    c4 = vx * py - vy * px;
    den3 = r2 * rt;
    num[0] = (px <<< FRAC_W);
    num[1] = (py <<< FRAC_W);
    num[2] = -(py <<< 2 * FRAC_W);
    num[3] = (px <<< 2 * FRAC_W);
    num[4] = (py * c4) <<< FRAC_W;
    num[5] = -((px * c4) <<< FRAC_W);
    for (int k = 0; k < NFIELD; k++) begin
      e = clip_div(num[k], k < 2 ? rt : (k < 4 ? r2 : den3));
      r.d[k*DATA_W +: DATA_W] = e[31:0];
      r.sat |= e[32];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  int gap_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      // beat taken at this edge: predict with the register as it stands
      if (s_axis_tvalid && s_axis_tready) begin
        jac_q.push_back(jacobian_of(s_axis_tdata, min_r2));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else if (state_q.size() != 0) begin
          s_axis_tdata <= state_q.pop_front();
          s_axis_tvalid <= 1'b1;
          gap_cnt <= calm ? 0 : $urandom_range(0, 16);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------- long receiver hold-off
  bit hold_trig = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------- monitor
  int stall_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    int st;
    jac_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      st = stall_cnt != 0 ? stall_cnt - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        n_got++;
        st = calm ? 0 : $urandom_range(0, 16);
        if (jac_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = jac_q.pop_front();
          n_near += want.near;
          n_sat += want.sat;
          for (int k = 0; k < NFIELD; k++) begin
            if (m_axis_tdata[k*DATA_W +: DATA_W] !== want.d[k*DATA_W +: DATA_W]) begin
              n_err++;
              if (n_err <= 10)
                $display("beat %0d entry %0d: expected %h, got %h", n_got, k,
                         want.d[k*DATA_W +: DATA_W], m_axis_tdata[k*DATA_W +: DATA_W]);
            end
          end
          if (m_axis_tuser !== {want.sat, want.near}) begin
            n_err++;
            if (n_err <= 10)
              $display("beat %0d flags: expected %b, got %b", n_got,
                       {want.sat, want.near}, m_axis_tuser);
          end
        end
      end
      stall_cnt <= st;
      m_axis_tready <= (st == 0) && (hold_left == 0);
    end
  end

  // ------------------------------------------------------------- stimulus
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom) >>> $urandom_range(0, 31);
      2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom) >>> $urandom_range(14, 24);
    endcase
  endfunction

  task automatic add_state(logic [31:0] px, py, vx, vy);
    state_q.push_back({vy, vx, py, px});
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) add_state(rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // sender done and every predicted beat back, then let the pipe settle
  task automatic wait_idle();
    while (state_q.size() != 0 || s_axis_tvalid || jac_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_min_r2(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_r2 = v;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold of 7: zero range, tiny range, corners, saturation
    add_state(32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
    add_state(32'h1, 32'h0, 32'h0001_0000, 32'h0);
    add_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_state(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_state(32'h0000_0a00, 32'hffff_f600, 32'h7fff_ffff, 32'h8000_0000);
    add_state(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0003_0000);
    add_state(32'hffff_0000, 32'h0, 32'h0, 32'h0001_0000);
    add_state(32'h0, 32'hfffe_0000, 32'h0005_0000, 32'h0);
    add_random(150);
    wait_idle();

    // threshold 4: range squared exactly at and just under the limit
    write_min_r2(16'd4);
    add_state(32'd512, 32'd0, 32'h0001_0000, 32'h0);
    add_state(32'd511, 32'd0, 32'h0001_0000, 32'h0);
    add_state(32'd0, -32'sd512, 32'h0, 32'h0001_0000);
    add_state(32'd0, -32'sd511, 32'h0, 32'h0001_0000);
    add_random(150);
    wait_idle();

    // threshold 0: only an exact zero range is flagged
    write_min_r2(16'd0);
    add_state(32'd0, 32'd0, 32'h1234_5678, 32'h8765_4321);
    add_state(32'd1, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
    add_state(32'd1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_random(150);
    wait_idle();

    // no idling, then a long receiver hold-off while the sender keeps going
    calm = 1'b1;
    add_random(200);
    hold_trig = ~hold_trig;
    wait_idle();
    calm = 1'b0;

    // largest threshold
    write_min_r2(16'hffff);
    add_state(32'h00ff_ff80, 32'h0, 32'h0, 32'h0);
    add_state(32'h0100_0000, 32'h0, 32'h0, 32'h0);
    add_random(200);
    wait_idle();

    // a few random thresholds
    for (int ph = 0; ph < 3; ph++) begin
      write_min_r2(16'($urandom));
      add_random(100);
      wait_idle();
    end

    $display("sent %0d state vectors, checked %0d results (%0d near range, %0d clipped)",
             n_sent, n_got, n_near, n_sat);
    $display("thresholds 0, 4, 7, 65535 and random; gaps, stalls and a %0d cycle hold-off",
             HOLD_LEN);
    if (n_err == 0 && jac_q.size() == 0) begin
      $display("[radar_measurement_jacobian] OK");
    end else begin
      $display("%0d mismatches, %0d results never came", n_err, jac_q.size());
      $display("[radar_measurement_jacobian] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", jac_q.size());
    $display("[radar_measurement_jacobian] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rmj_pkg.sv
rtl/core/rmj_sqrt_cell.sv
rtl/core/rmj_div_cell.sv
rtl/core/radar_measurement_jacobian.sv
test/radar_measurement_jacobian_tb.sv
